// File: rtl/mrw_pkg.sv
// ----------------------------------------------------------------------------
// mrw_pkg: shared types and constants for the Miller-Rabin witness test
// Datapath commands, status bundle and handshake widths.
// ----------------------------------------------------------------------------
package mrw_pkg;

    localparam int FIELD_W      = 64;  // width of candidate and base on the ports
    localparam int WORD_BITS_DEF = 64; // default arithmetic width

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,        // capture candidate and base, clear remainder
        DP_RED,         // one bit of base mod n
        DP_SPLIT,       // shift one trailing zero out of n-1
        DP_POW_INIT,    // x = 1, restart exponent scan
        DP_SQ_START,    // start x*x mod n
        DP_SQ_DEC,      // start x*x mod n and count one squaring off s
        DP_MB_START,    // start x*base mod n
        DP_MUL_STEP,    // one shift-add bit of the modular product
        DP_EXP_SHIFT    // advance to the next exponent bit
    } t_dp_op;

    typedef struct packed {
        logic small_prime; // n is 2 or 3
        logic bad_n;       // n below 2 or even
        logic step_last;   // bit counter on its final step
        logic exp_even;
        logic exp_bit;
        logic exp_last;
        logic x_one;
        logic x_nm1;
        logic s_le1;
    } t_dp_status;

    typedef struct packed {
        logic valid;
        logic pass;
    } t_fin;

endpackage

// File: rtl/mrw_if.sv
// ----------------------------------------------------------------------------
// mrw_req_if / mrw_res_if: request and result channels
// Valid/ready handshake with the witness test payload.
// ----------------------------------------------------------------------------
interface mrw_req_if import mrw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] candidate;
    logic [FIELD_W-1:0] base;
    logic               last_base;

    modport source (output valid, candidate, base, last_base, input ready);
    modport sink   (input valid, candidate, base, last_base, output ready);
endinterface

interface mrw_res_if;
    logic valid;
    logic ready;
    logic round_pass;
    logic group_verdict;
    logic group_done;

    modport source (output valid, round_pass, group_verdict, group_done, input ready);
    modport sink   (input valid, round_pass, group_verdict, group_done, output ready);
endinterface

// File: rtl/miller_rabin_witness_test.sv
// ----------------------------------------------------------------------------
// miller_rabin_witness_test: one Miller-Rabin strong probable prime round
// Controller, datapath, result register and running group verdict.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries a request: candidate n, witness base and last_base, which
//   closes a group of rounds on the same candidate. o_res returns one result
//   per request: round_pass, group_verdict (AND of the group so far) and
//   group_done (copy of last_base). Only the low WORD_BITS bits of candidate
//   and base are used.
//   One request is worked at a time; i_req.ready is high only while idle.
//   The work is set by the shift-add modular multiplier, one product bit per
//   cycle: base mod n, then splitting n-1, then W exponent bits, each with a
//   square and shift plus a multiply when the bit is set, then up to s-1
//   further squarings. n of 2, 3, even or below 2 goes straight to the result.
//   The result waits in an output register; a stalled receiver holds the
//   next finished round in the controller until the register frees.
//   Reset returns to idle, drops any pending result and sets the group
//   verdict to pass.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test import mrw_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mrw_req_if.sink  i_req,
    mrw_res_if.source o_res
);
    t_dp_op     op;
    t_dp_status status;
    t_fin       fin;
    logic       out_free;
    logic       req_ready;

    logic r_ovalid, r_opass, r_overdict, r_odone;
    logic r_group_passed;
    logic r_last;           // last_base of the request in flight
    logic verdict;

    assign i_req.ready = req_ready;
    assign out_free    = !r_ovalid || o_res.ready;
    assign verdict     = r_group_passed & fin.pass;

    mrw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_out_free  (out_free),
        .i_status    (status),
        .o_req_ready (req_ready),
        .o_op        (op),
        .o_fin       (fin)
    );

    mrw_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_op        (op),
        .i_candidate (i_req.candidate),
        .i_base      (i_req.base),
        .o_status    (status)
    );

    // hold the group flag of the request in flight
    always_ff @(posedge i_clk) begin
        if (i_req.valid && req_ready) begin
            r_last <= i_req.last_base;
        end
    end

    // result register and running verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid       <= 1'b0;
            r_group_passed <= 1'b1;
        end else begin
            if (fin.valid) begin
                r_ovalid       <= 1'b1;
                r_group_passed <= r_last ? 1'b1 : verdict;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin.valid) begin
            r_opass    <= fin.pass;
            r_overdict <= verdict;
            r_odone    <= r_last;
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.round_pass    = r_opass;
    assign o_res.group_verdict = r_overdict;
    assign o_res.group_done    = r_odone;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && req_ready) |=> !req_ready)
        else $error("request taken while a round is in flight");

    a_fin_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin.valid |-> out_free)
        else $error("result overwrote an undelivered one");

    a_group_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin.valid && r_last) |=> r_group_passed)
        else $error("group verdict not restored after closing round");

    a_verdict_implies_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (!r_overdict || r_opass))
        else $error("group verdict passes a failed round");
`endif

endmodule

// File: rtl/mrw_datapath.sv
// ----------------------------------------------------------------------------
// mrw_datapath: operand registers and the shift-add modular multiplier
// Reduces the base, splits n-1 and runs one product bit per cycle.
// ----------------------------------------------------------------------------
module mrw_datapath import mrw_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  t_dp_op             i_op,
    input  logic [FIELD_W-1:0] i_candidate,
    input  logic [FIELD_W-1:0] i_base,
    output t_dp_status         o_status
);
    localparam int W  = WORD_BITS;
    localparam int SW = $clog2(WORD_BITS);

    logic [W-1:0]  r_n, r_mb, r_ma, r_acc, r_x, r_rem, r_exp;
    logic [SW-1:0] r_s, r_cnt, r_ecnt;

    logic [W-1:0] nm1, red_nx, dbl_r, sum_r, acc_nx;
    logic [W:0]   rem2, dbl, sum;

    assign nm1  = r_n - W'(1);

    // restoring reduction: remainder stays below n
    assign rem2   = {r_rem, r_mb[W-1]};
    assign red_nx = (rem2 >= {1'b0, r_n}) ? W'(rem2 - {1'b0, r_n}) : rem2[W-1:0];

    // double, then add multiplicand when the multiplier bit is set
    assign dbl    = {r_acc, 1'b0};
    assign dbl_r  = (dbl >= {1'b0, r_n}) ? W'(dbl - {1'b0, r_n}) : dbl[W-1:0];
    assign sum    = {1'b0, dbl_r} + {1'b0, r_ma};
    assign sum_r  = (sum >= {1'b0, r_n}) ? W'(sum - {1'b0, r_n}) : sum[W-1:0];
    assign acc_nx = r_mb[W-1] ? sum_r : dbl_r;

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_n   <= i_candidate[W-1:0];
                r_mb  <= i_base[W-1:0];
                r_exp <= i_candidate[W-1:0] - W'(1);
                r_rem <= '0;
                r_cnt <= '0;
                r_s   <= '0;
            end
            DP_RED: begin
                r_rem <= red_nx;
                r_mb  <= r_mb << 1;
                r_cnt <= r_cnt + SW'(1);
            end
            DP_SPLIT: begin
                r_exp <= r_exp >> 1;
                r_s   <= r_s + SW'(1);
            end
            DP_POW_INIT: begin
                r_x    <= W'(1);
                r_ecnt <= '0;
            end
            DP_SQ_START, DP_SQ_DEC: begin
                r_ma  <= r_x;
                r_mb  <= r_x;
                r_acc <= '0;
                r_cnt <= '0;
                if (i_op == DP_SQ_DEC) begin
                    r_s <= r_s - SW'(1);
                end
            end
            DP_MB_START: begin
                r_ma  <= r_x;
                r_mb  <= r_rem;
                r_acc <= '0;
                r_cnt <= '0;
            end
            DP_MUL_STEP: begin
                r_acc <= acc_nx;
                r_mb  <= r_mb << 1;
                r_cnt <= r_cnt + SW'(1);
                if (r_cnt == SW'(W - 1)) begin
                    r_x <= acc_nx;
                end
            end
            DP_EXP_SHIFT: begin
                r_exp  <= r_exp << 1;
                r_ecnt <= r_ecnt + SW'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.small_prime = (r_n == W'(2)) || (r_n == W'(3));
        o_status.bad_n       = (r_n < W'(2)) || !r_n[0];
        o_status.step_last   = (r_cnt == SW'(W - 1));
        o_status.exp_even    = !r_exp[0];
        o_status.exp_bit     = r_exp[W-1];
        o_status.exp_last    = (r_ecnt == SW'(W - 1));
        o_status.x_one       = (r_x == W'(1));
        o_status.x_nm1       = (r_x == nm1);
        o_status.s_le1       = (r_s <= SW'(1));
    end

endmodule

// File: rtl/mrw_ctrl.sv
// ----------------------------------------------------------------------------
// mrw_ctrl: sequencer for one witness round
// Steps reduction, split, exponentiation and squarings; reports the verdict.
// ----------------------------------------------------------------------------
module mrw_ctrl import mrw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_out_free,
    input  t_dp_status i_status,
    output logic       o_req_ready,
    output t_dp_op     o_op,
    output t_fin       o_fin
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_CLASS = 14'b00000000000010,
        S_RED   = 14'b00000000000100,
        S_SPLIT = 14'b00000000001000,
        S_PSQ   = 14'b00000000010000,
        S_PMSQ  = 14'b00000000100000,
        S_PBM   = 14'b00000001000000,
        S_PMB   = 14'b00000010000000,
        S_PNEXT = 14'b00000100000000,
        S_CHECK = 14'b00001000000000,
        S_SQ    = 14'b00010000000000,
        S_SQM   = 14'b00100000000000,
        S_SQCHK = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        o_op        = DP_NOP;
        o_req_ready = 1'b0;
        o_fin       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_op    = DP_LOAD;
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_status.small_prime) begin
                    n_pass  = 1'b1;
                    n_state = S_DONE;
                end else if (i_status.bad_n) begin
                    n_pass  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RED;
                end
            end
            S_RED: begin
                o_op = DP_RED;
                if (i_status.step_last) begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (i_status.exp_even) begin
                    o_op = DP_SPLIT;
                end else begin
                    o_op    = DP_POW_INIT;
                    n_state = S_PSQ;
                end
            end
            S_PSQ: begin
                o_op    = DP_SQ_START;
                n_state = S_PMSQ;
            end
            S_PMSQ: begin
                o_op = DP_MUL_STEP;
                if (i_status.step_last) begin
                    n_state = i_status.exp_bit ? S_PBM : S_PNEXT;
                end
            end
            S_PBM: begin
                o_op    = DP_MB_START;
                n_state = S_PMB;
            end
            S_PMB: begin
                o_op = DP_MUL_STEP;
                if (i_status.step_last) begin
                    n_state = S_PNEXT;
                end
            end
            S_PNEXT: begin
                o_op    = DP_EXP_SHIFT;
                n_state = i_status.exp_last ? S_CHECK : S_PSQ;
            end
            S_CHECK: begin
                if (i_status.x_one || i_status.x_nm1) begin
                    n_pass  = 1'b1;
                    n_state = S_DONE;
                end else if (i_status.s_le1) begin
                    n_pass  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_op    = DP_SQ_DEC;
                n_state = S_SQM;
            end
            S_SQM: begin
                o_op = DP_MUL_STEP;
                if (i_status.step_last) begin
                    n_state = S_SQCHK;
                end
            end
            S_SQCHK: begin
                if (i_status.x_nm1) begin
                    n_pass  = 1'b1;
                    n_state = S_DONE;
                end else if (i_status.x_one || i_status.s_le1) begin
                    n_pass  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_fin.valid = 1'b1;
                    o_fin.pass  = r_pass;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

endmodule
